// ===== rtl/dfr_pkg.sv =====
// Shared types, codes and defaults for the delimited frame receiver.
`default_nettype none

package dfr_pkg;

    localparam int MAX_DELIMITER_BYTES_DEF = 8;
    localparam int MAX_FRAME_BYTES_DEF     = 4096;

    // Fixed field widths of the interface.
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 12;
    localparam int FLEN_W     = 13;
    localparam int DLEN_CFG_W = 4;
    localparam int PAT_CFG_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int TDATA_O_W  = 40;
    localparam int TUSER_O_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DLEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXLEN  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [PAT_CFG_W-1:0]  PATTERN_RST = 64'd10;
    localparam logic [DLEN_CFG_W-1:0] DLEN_RST    = 4'd1;
    localparam logic [FLEN_W-1:0]     MAXLEN_RST  = 13'd4096;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_FOUND    = 2'd1,
        ST_CLOSED   = 2'd2,
        ST_OVERFLOW = 2'd3
    } frame_status_t;

    // One window lane as it moves from cell to cell.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
    } lane_t;

    // Per-word control broadcast to every cell.
    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        frame_status_t       frame_status;
        logic                frame_done;
        logic [FLEN_W-1:0]   frame_length;
        logic                store_valid;
        logic [POS_W-1:0]    byte_position;
        logic [BYTE_W-1:0]   stored_byte;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/delimited_frame_receiver.sv =====
// Top level of the delimited frame receiver: cell window, frame counter and output stage.
//
// The s_ channel carries one received byte per word in s_tdata; s_tuser high
// marks a link-closed event instead of a byte. Every accepted word gives exactly
// one result word on the m_ channel: the byte and its frame position for the
// frame buffer, the frame length so far, and a status. m_tlast marks the last
// result of a frame (delimiter found, link closed or overflow).
// The cfg channel writes the delimiter pattern, its length and the frame length
// limit; cfg_ready is always high and writes are meant for an idle block.
// The delimiter window is a row of byte cells, one per delimiter byte, that
// shift together and compare their lanes in parallel, so one word is accepted
// every cycle while s_tready is high; results leave through a registered output stage.
// Reset empties the window, the frame counter and the output stage and loads
// the register defaults (line feed delimiter, length 1, limit 4096).
// When the receiver stalls, one further word is taken into a skid register;
// after that s_tready drops until the result on m_ is taken, and no result
// is lost or repeated.
`default_nettype none

module delimited_frame_receiver #(
    parameter int MAX_DELIMITER_BYTES = dfr_pkg::MAX_DELIMITER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES     = dfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [7:0]                         s_tdata,   // [7:0] rx_byte
    input  wire                                s_tuser,   // [0] link_closed
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [7:0] stored_byte, [19:8] byte_position, [32:20] frame_length, [39:33] zero
    output logic [dfr_pkg::TDATA_O_W-1:0]      m_tdata,
    output logic [dfr_pkg::TUSER_O_W-1:0]      m_tuser,   // [0] store_valid, [2:1] frame_status
    output logic                               m_tlast,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [dfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [dfr_pkg::PAT_CFG_W-1:0]      cfg_data
);

    localparam int PAT_W = 8 * MAX_DELIMITER_BYTES;
    localparam int DL_W  = $clog2(MAX_DELIMITER_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [PAT_W-1:0]                   pat_reg;
    logic [dfr_pkg::DLEN_CFG_W-1:0]     dlen_reg;
    logic [dfr_pkg::FLEN_W-1:0]         maxlen_reg;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;

    logic [DL_W-1:0]                    dlen_eff;
    logic [CNT_W-1:0]                   limit_eff;
    logic [CNT_W-1:0]                   count;
    logic                               closed;
    logic                               accept;
    logic                               match;
    logic                               over;
    logic                               terminal;
    logic                               core_ready;
    logic                               out_valid;
    dfr_pkg::frame_status_t             status;
    dfr_pkg::cell_ctrl_t                ctrl;
    dfr_pkg::lane_t                     chain [0:MAX_DELIMITER_BYTES];
    logic [MAX_DELIMITER_BYTES-1:0]     lane_ok;
    dfr_pkg::result_t                   res;
    dfr_pkg::result_t                   out_res;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg    <= dfr_pkg::PATTERN_RST[PAT_W-1:0];
            dlen_reg   <= dfr_pkg::DLEN_RST;
            maxlen_reg <= dfr_pkg::MAXLEN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                dfr_pkg::REG_PATTERN: pat_reg    <= cfg_data[PAT_W-1:0];
                dfr_pkg::REG_DLEN:    dlen_reg   <= cfg_data[dfr_pkg::DLEN_CFG_W-1:0];
                dfr_pkg::REG_MAXLEN:  maxlen_reg <= cfg_data[dfr_pkg::FLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A length of zero acts as one, and values beyond the hardware are clamped.
    always_comb begin
        if (dlen_reg == '0) begin
            dlen_eff = DL_W'(1);
        end else if (32'(dlen_reg) > MAX_DELIMITER_BYTES) begin
            dlen_eff = DL_W'(MAX_DELIMITER_BYTES);
        end else begin
            dlen_eff = DL_W'(dlen_reg);
        end
        if (maxlen_reg == '0) begin
            limit_eff = CNT_W'(1);
        end else if (32'(maxlen_reg) > MAX_FRAME_BYTES) begin
            limit_eff = CNT_W'(MAX_FRAME_BYTES);
        end else begin
            limit_eff = CNT_W'(maxlen_reg);
        end
    end

    assign closed = s_tuser;
    assign accept = s_tvalid && core_ready;
    assign count  = cnt_reg + CNT_W'(1);

    // The newest byte enters the first cell; every cell passes its byte on.
    assign chain[0].data  = s_tdata;
    assign chain[0].valid = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DELIMITER_BYTES; gi++) begin : g_cell
            dfr_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .pat_byte (pat_reg[8*gi +: 8]),
                .lane_en  (DL_W'(gi) < dlen_eff),
                .prev     (chain[gi]),
                .cur      (chain[gi+1]),
                .lane_ok  (lane_ok[gi])
            );
        end
    endgenerate

    // A lane that still lacks a byte of this frame fails, which covers short frames.
    assign match    = !closed && (&lane_ok);
    assign over     = !closed && !match && (count >= limit_eff);
    assign terminal = closed || match || over;

    assign ctrl.advance = accept;
    assign ctrl.clear   = terminal;

    always_comb begin
        if (closed) begin
            status = dfr_pkg::ST_CLOSED;
        end else if (match) begin
            status = dfr_pkg::ST_FOUND;
        end else if (over) begin
            status = dfr_pkg::ST_OVERFLOW;
        end else begin
            status = dfr_pkg::ST_CONTINUE;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = terminal ? '0 : count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        res.stored_byte   = closed ? '0 : s_tdata;
        res.byte_position = closed ? '0 : dfr_pkg::POS_W'(cnt_reg);
        res.store_valid   = !closed;
        res.frame_length  = closed ? dfr_pkg::FLEN_W'(cnt_reg) : dfr_pkg::FLEN_W'(count);
        res.frame_status  = status;
        res.frame_done    = terminal;
    end

    dfr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (core_ready),
        .in_data   (res),
        .out_valid (out_valid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign s_tready = core_ready;
    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, out_res.frame_length, out_res.byte_position, out_res.stored_byte};
    assign m_tuser  = {out_res.frame_status, out_res.store_valid};
    assign m_tlast  = out_res.frame_done;

    // Assertions.
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_last_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[2:1] != dfr_pkg::ST_CONTINUE)))
        else $error("frame end flag disagrees with status");

    a_window_within_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[MAX_DELIMITER_BYTES].valid |-> (32'(cnt_reg) >= MAX_DELIMITER_BYTES))
        else $error("window holds more bytes than the current frame");

    a_closed_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == dfr_pkg::ST_CLOSED)) |-> !m_tuser[0])
        else $error("link-closed result marked as a store");

endmodule

`default_nettype wire

// ===== rtl/dfr_cell.sv =====
// One window cell: holds a byte of the current frame and checks one delimiter lane.
`default_nettype none

module dfr_cell (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  dfr_pkg::cell_ctrl_t              ctrl,
    input  wire  [dfr_pkg::BYTE_W-1:0]       pat_byte,
    input  wire                              lane_en,
    input  dfr_pkg::lane_t                   prev,
    output dfr_pkg::lane_t                   cur,
    output logic                             lane_ok
);

    logic [dfr_pkg::BYTE_W-1:0] data_reg;
    logic                       valid_reg;

    // The compare looks at the byte this cell will hold after the shift.
    assign lane_ok = !lane_en || (prev.valid && (prev.data == pat_byte));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            valid_reg <= ctrl.clear ? 1'b0 : prev.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            data_reg <= prev.data;
        end
    end

    assign cur.data  = data_reg;
    assign cur.valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/dfr_skid.sv =====
// Two-entry output register that lets the input side run while a result waits.
`default_nettype none

module dfr_skid (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  dfr_pkg::result_t   in_data,
    output logic               out_valid,
    input  wire                out_ready,
    output dfr_pkg::result_t   out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    dfr_pkg::result_t  out_data_reg, out_data_next;
    dfr_pkg::result_t  skid_data_reg, skid_data_next;
    logic              accept;
    logic              take;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = accept;
                if (accept) begin
                    skid_data_next = in_data;
                end
            end else begin
                out_valid_next = accept;
                if (accept) begin
                    out_data_next = in_data;
                end
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== verif/delimited_frame_receiver_tb.sv =====
// Self-checking testbench for the delimited frame receiver: directed frames, then random ones.
`timescale 1ns / 100ps

module delimited_frame_receiver_tb;

    localparam int QUIET_LIMIT      = 1000;
    localparam int PHASE_WORDS      = 100;
    localparam int RANDOM_PHASES    = 12;
    localparam int LONG_FRAME_WORDS = 512;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = 8'd0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [dfr_pkg::TDATA_O_W-1:0]  m_tdata;
    logic [dfr_pkg::TUSER_O_W-1:0]  m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index = dfr_pkg::REG_PATTERN;
    logic [dfr_pkg::PAT_CFG_W-1:0]  cfg_data  = '0;

    // Register copies and frame state of the predictor.
    logic [63:0]           pat_reg;
    logic [3:0]            dlen_reg;
    logic [12:0]           maxlen_reg;
    logic [63:0]           win_bytes;
    int unsigned           win_count;

    dfr_pkg::result_t      pending_results[$];
    int unsigned           words_sent;
    int unsigned           burst_left;
    int unsigned           mismatches;
    int unsigned           results_seen;
    int unsigned           frames_found;
    int unsigned           frames_closed;
    int unsigned           frames_overflow;
    int unsigned           config_phases;
    int unsigned           quiet_cycles;
    int unsigned           stall_left;
    int unsigned           stall_mode;
    logic [7:0]            ready_pattern;

    delimited_frame_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int unsigned delim_bytes();
        if (dlen_reg == 4'd0) return 1;
        if (32'(dlen_reg) > dfr_pkg::MAX_DELIMITER_BYTES_DEF)
            return dfr_pkg::MAX_DELIMITER_BYTES_DEF;
        return 32'(dlen_reg);
    endfunction

    function automatic int unsigned frame_limit();
        if (maxlen_reg == 13'd0) return 1;
        if (32'(maxlen_reg) > dfr_pkg::MAX_FRAME_BYTES_DEF) return dfr_pkg::MAX_FRAME_BYTES_DEF;
        return 32'(maxlen_reg);
    endfunction

    // Works out the result of one accepted word and advances the frame state.
    function automatic dfr_pkg::result_t predict_frame_result(input logic [7:0] rx,
                                                             input logic closed);
        dfr_pkg::result_t r;
        int unsigned      dl;
        int unsigned      cnt;
        logic [63:0]      mask;
        logic             hit;
        r  = '0;
        dl = delim_bytes();
        if (closed) begin
            r.frame_length = win_count[12:0];
            r.frame_status = dfr_pkg::ST_CLOSED;
            r.frame_done   = 1'b1;
            win_bytes      = '0;
            win_count      = 0;
        end else begin
            r.stored_byte   = rx;
            r.byte_position = win_count[11:0];
            r.store_valid   = 1'b1;
            win_bytes       = {win_bytes[55:0], rx};
            cnt             = win_count + 1;
            r.frame_length  = cnt[12:0];
            mask = (dl >= 8) ? {64{1'b1}} : ((64'd1 << (dl * 8)) - 64'd1);
            // Only bytes of the current frame may complete the delimiter.
            hit  = (cnt >= dl) && ((win_bytes & mask) == (pat_reg & mask));
            if (hit || cnt >= frame_limit()) begin
                r.frame_status = hit ? dfr_pkg::ST_FOUND : dfr_pkg::ST_OVERFLOW;
                r.frame_done   = 1'b1;
                win_bytes      = '0;
                win_count      = 0;
            end else begin
                r.frame_status = dfr_pkg::ST_CONTINUE;
                win_count      = cnt;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    // Sends one word; the sender runs in bursts of random length with gaps between.
    task automatic send_word(input logic [7:0] rx, input logic closed);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tuser  <= closed;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_frame_result(rx, closed));
        words_sent++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [dfr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dfr_pkg::REG_PATTERN: pat_reg    = value;
            dfr_pkg::REG_DLEN:    dlen_reg   = value[3:0];
            dfr_pkg::REG_MAXLEN:  maxlen_reg = value[12:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] dl, input logic [12:0] ml);
        hold_until_drained();
        write_reg(dfr_pkg::REG_PATTERN, pat);
        write_reg(dfr_pkg::REG_DLEN, {60'd0, dl});
        write_reg(dfr_pkg::REG_MAXLEN, {51'd0, ml});
        cfg_valid <= 1'b0;
        config_phases++;
    endtask

    // Sends the first n bytes of the delimiter, first byte from the highest used lane.
    task automatic send_delimiter(input int unsigned n);
        int unsigned dl;
        dl = delim_bytes();
        for (int unsigned i = 0; i < n; i++)
            send_word(pat_reg[8 * (dl - 1 - i) +: 8], 1'b0);
    endtask

    // Frame content: half the time a delimiter byte, to provoke partial and overlapping matches.
    function automatic logic [7:0] content_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom);
        return pat_reg[8 * $urandom_range(0, delim_bytes() - 1) +: 8];
    endfunction

    task automatic test_default_delimiter();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h0A, 1'b0);
        send_word(8'hFF, 1'b1);    // close on an empty frame
        send_word(8'h55, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_multibyte_delimiter();
        configure(64'hFFFF_FFFF_FFFF_0D0A, 4'd2, 13'd16);
        send_word(8'h0D, 1'b0);
        send_word(8'h00, 1'b1);
        // The carriage return belongs to the closed frame, so this line feed alone must not match.
        send_word(8'h0A, 1'b0);
        send_word(8'h0D, 1'b0);
        send_word(8'h0A, 1'b0);
    endtask

    task automatic test_limit_boundaries();
        configure(64'h7E, 4'd1, 13'd3);
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h7E, 1'b0);    // match on the limit byte: delimiter wins
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h03, 1'b0);
    endtask

    task automatic test_register_saturation();
        configure(64'hAA, 4'd0, 13'd0);
        send_word(8'hAA, 1'b0);
        send_word(8'h00, 1'b0);
        configure(64'h0102_0304_0506_0708, 4'd15, 13'd8191);
        send_delimiter(8);
    endtask

    task automatic test_full_frame();
        configure({$urandom, $urandom}, 4'd8, 13'(LONG_FRAME_WORDS));
        repeat (LONG_FRAME_WORDS) send_word(8'($urandom), 1'b0);
    endtask

    task automatic test_random_frames();
        logic [63:0] pat;
        logic [3:0]  dl;
        logic [12:0] ml;
        logic [7:0]  fill;
        int unsigned stop_at;
        int unsigned k;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: begin
                    fill = 8'($urandom);
                    pat  = {8{fill}};
                end
                1: for (int i = 0; i < 8; i++) pat[8 * i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
                default: pat = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 9))
                0: dl = 4'd0;
                1: dl = 4'($urandom_range(9, 15));
                default: dl = 4'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 7))
                0: ml = 13'd1;
                1: ml = 13'd4096;
                2: ml = 13'($urandom_range(4097, 8191));
                default: ml = 13'($urandom_range(2, 40));
            endcase
            configure(pat, dl, ml);
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at) begin
                case ($urandom_range(0, 9))
                    0: send_word(8'($urandom), 1'b1);
                    1: begin
                        // Broken delimiter: a proper prefix followed by a random byte.
                        k = $urandom_range(0, delim_bytes() - 1);
                        send_delimiter(k);
                        send_word(8'($urandom), 1'b0);
                    end
                    2: repeat ($urandom_range(1, 10))
                        send_word(8'($urandom), $urandom_range(0, 15) == 0);
                    default: begin
                        repeat ($urandom_range(0, 12)) send_word(content_byte(), 1'b0);
                        send_delimiter(delim_bytes());
                    end
                endcase
                if ($urandom_range(0, 60) == 0) hold_until_drained();
            end
        end
    endtask

    // Receiver stalls: runs of always ready, random ready, and a rotating pattern.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode    = $urandom_range(0, 2);
            stall_left    = $urandom_range(20, 200);
            ready_pattern = 8'($urandom) | 8'h01;
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
                m_tready <= ready_pattern[0];
            end
        endcase
    end

    always @(posedge aclk) begin : result_check
        dfr_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result word with nothing expected, actual tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("stored_byte", 16'(want.stored_byte), 16'(m_tdata[7:0]));
                check_field("byte_position", 16'(want.byte_position), 16'(m_tdata[19:8]));
                check_field("frame_length", 16'(want.frame_length), 16'(m_tdata[32:20]));
                check_field("store_valid", 16'(want.store_valid), 16'(m_tuser[0]));
                check_field("frame_status", 16'(want.frame_status), 16'(m_tuser[2:1]));
                check_field("frame_done", 16'(want.frame_done), 16'(m_tlast));
                case (want.frame_status)
                    dfr_pkg::ST_FOUND:    frames_found++;
                    dfr_pkg::ST_CLOSED:   frames_closed++;
                    dfr_pkg::ST_OVERFLOW: frames_overflow++;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: timeout, %0d results still expected", $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        pat_reg    = dfr_pkg::PATTERN_RST;
        dlen_reg   = dfr_pkg::DLEN_RST;
        maxlen_reg = dfr_pkg::MAXLEN_RST;
        win_bytes  = '0;
        win_count  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_delimiter();
        test_multibyte_delimiter();
        test_limit_boundaries();
        test_register_saturation();
        test_full_frame();
        test_random_frames();

        hold_until_drained();
        repeat (4) @(posedge aclk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Sent %0d words over %0d register settings, checked %0d results.",
                 words_sent, config_phases + 1, results_seen);
        $display("Frames ended: %0d on delimiter, %0d on close, %0d on overflow; %0d mismatches.",
                 frames_found, frames_closed, frames_overflow, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dfr_pkg.sv
rtl/dfr_cell.sv
rtl/dfr_skid.sv
rtl/delimited_frame_receiver.sv
verif/delimited_frame_receiver_tb.sv
